// File: rtl/urxrw_pkg.sv
// ----------------------------------------------------------------------------
// urxrw_pkg
// Shared codes, widths and command/status types of the receive ring block.
// ----------------------------------------------------------------------------
package urxrw_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_POLL  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // result kinds
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // store status codes
    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DISABLED = 2'd2;

    // most bytes one read drains
    localparam int unsigned MAX_OUT = 63;
    localparam int unsigned CNT_W   = 6;

    localparam int unsigned MASK_W = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic item_load;   // latch the incoming item
        logic single;      // commit item, load its single result
        logic rd_start;    // load the drain count
        logic rd_issue;    // read one byte from the ring, advance read index
        logic rd_load;     // move the read byte into the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  item_op;     // latched operation
        logic rd_empty;    // read drains nothing
        logic cnt_zero;    // no byte left after the current one
        logic out_free;    // output register can take a result this cycle
    } stat_t;

endpackage

// File: rtl/uart_rx_ring_watermark.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_watermark
// Per-port receive rings with a half-full ready flag, store/poll/read items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries op, port, rx_byte, read_max.
//   A store or poll gives one result; a read gives one result per drained
//   byte (up to 63), the final one marked by last, or a single result with
//   data_valid low if nothing is drained. Op code 3 is taken and dropped.
//   Output channel (out_valid/out_stall) carries one result per transfer.
//   Config channel (cfg_valid/cfg_ready) writes rx_enable_mask; cfg_ready
//   is always high, writes are expected only while the block is idle.
// Sequencing:
//   One item at a time. A store or poll result passes the item registers,
//   then enters the output register in the execute step once it is free.
//   A read moves each byte by a ring memory read, then an output register
//   load, and takes no new item until its last byte is loaded.
//   A pending result may wait under stall while the next item is taken;
//   the item then holds in its execute step until the register frees.
// Reset:
//   rst_n clears indexes, ready flags, enable mask and all control state;
//   ring contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module uart_rx_ring_watermark
    import urxrw_pkg::*;
#(
    parameter int unsigned RING_SIZE = 64,
    parameter int unsigned NUM_PORTS = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input items
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic              port,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        read_max,
    // results
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [1:0]        store_status,
    output logic              ready_res,
    output logic [7:0]        data,
    output logic              data_valid,
    output logic              last,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MASK_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // config always taken
    assign cfg_ready = 1'b1;

    // controller
    urxrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (op_t'(op)),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // datapath
    urxrw_dp #(
        .RING_SIZE (RING_SIZE),
        .NUM_PORTS (NUM_PORTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .port         (port),
        .rx_byte      (rx_byte),
        .read_max     (read_max),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .store_status (store_status),
        .ready_res    (ready_res),
        .data         (data),
        .data_valid   (data_valid),
        .last         (last)
    );

endmodule

// File: rtl/urxrw_ctrl.sv
// ----------------------------------------------------------------------------
// urxrw_ctrl
// Controller: sequences one item at a time through execute and drain steps.
// ----------------------------------------------------------------------------
module urxrw_ctrl
    import urxrw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  op_t   in_op,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  in_stall
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // input is taken only between items
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    if (in_op != OP_NONE)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.item_op == OP_READ && !stat.rd_empty)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_ISSUE;
                    end
                    else
                    begin
                        cmd.single = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_load = 1'b1;
                    state_next  = stat.cnt_zero ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/urxrw_dp.sv
// ----------------------------------------------------------------------------
// urxrw_dp
// Datapath: ring memory, per-port indexes and flags, item and output registers.
// ----------------------------------------------------------------------------
module urxrw_dp
    import urxrw_pkg::*;
#(
    parameter int unsigned RING_SIZE = 64,
    parameter int unsigned NUM_PORTS = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    // item fields
    input  logic [1:0]        op,
    input  logic              port,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        read_max,
    // configuration
    input  logic              cfg_write,
    input  logic [MASK_W-1:0] cfg_data,
    // result register
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [1:0]        store_status,
    output logic              ready_res,
    output logic [7:0]        data,
    output logic              data_valid,
    output logic              last
);

    localparam int unsigned IW    = $clog2(RING_SIZE);
    localparam int unsigned PW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int unsigned DEPTH = NUM_PORTS * RING_SIZE;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned HALF  = RING_SIZE / 2;

    localparam logic [IW:0]    RS_V   = (IW + 1)'(RING_SIZE);
    localparam logic [IW:0]    HALF_V = (IW + 1)'(HALF);
    localparam logic [8:0]     MAX_V  = 9'(MAX_OUT);

    // next index with wrap at the ring end
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        logic [IW:0] sum;
        sum = {1'b0, idx} + (IW + 1)'(1);
        if (sum >= RS_V)
        begin
            return '0;
        end
        return sum[IW-1:0];
    endfunction

    // distance from b forward to a around the ring
    function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + RS_V - {1'b0, b};
        end
        return d[IW-1:0];
    endfunction

    // state
    logic [7:0]        ring_mem [DEPTH];
    logic [IW-1:0]     wi_reg   [NUM_PORTS];
    logic [IW-1:0]     ri_reg   [NUM_PORTS];
    logic              flag_reg [NUM_PORTS];
    logic [MASK_W-1:0] mask_reg;

    // item registers
    op_t               item_op_reg;
    logic              item_port_reg;
    logic [7:0]        item_byte_reg;
    logic [7:0]        item_max_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [7:0]        mem_q_reg;

    // output register
    logic              out_valid_reg;
    logic [1:0]        kind_reg;
    logic [1:0]        status_reg;
    logic              ready_reg;
    logic [7:0]        data_reg;
    logic              dvalid_reg;
    logic              last_reg;

    // per-item combinational view
    logic              port_ok;
    logic [PW-1:0]     pidx;
    logic [IW-1:0]     wi_cur;
    logic [IW-1:0]     ri_cur;
    logic              flag_cur;
    logic [IW-1:0]     wi_inc;
    logic              ring_full;
    logic              ring_empty;
    logic [IW-1:0]     fill_after;
    logic [IW-1:0]     fill_now;
    logic [8:0]        lim_a;
    logic [8:0]        lim_b;
    logic [CNT_W-1:0]  rd_n;
    logic              en_bit;
    logic [1:0]        st_code;
    logic              poll_ans;
    logic [AW-1:0]     base_addr;
    logic              out_take;

    assign port_ok    = (32'(item_port_reg) < NUM_PORTS);
    assign pidx       = PW'(item_port_reg);
    assign wi_cur     = wi_reg[pidx];
    assign ri_cur     = ri_reg[pidx];
    assign flag_cur   = flag_reg[pidx];
    assign wi_inc     = idx_inc(wi_cur);
    assign ring_full  = (wi_inc == ri_cur);
    assign ring_empty = (wi_cur == ri_cur);
    assign fill_after = idx_dist(wi_inc, ri_cur);
    assign fill_now   = idx_dist(wi_cur, ri_cur);
    assign en_bit     = mask_reg[item_port_reg];
    assign base_addr  = AW'(item_port_reg) * AW'(RING_SIZE);

    // drain length: smallest of request, fill and cap
    always_comb
    begin
        lim_a = (9'(fill_now) < {1'b0, item_max_reg}) ? 9'(fill_now)
                                                      : {1'b0, item_max_reg};
        lim_b = (lim_a < MAX_V) ? lim_a : MAX_V;
        rd_n  = port_ok ? lim_b[CNT_W-1:0] : '0;
    end

    // store outcome and poll answer
    always_comb
    begin
        priority if (!port_ok || !en_bit)
        begin
            st_code = ST_DISABLED;
        end
        else if (ring_full)
        begin
            st_code = ST_FULL;
        end
        else
        begin
            st_code = ST_STORED;
        end
        poll_ans = port_ok && !ring_empty && flag_cur;
    end

    assign out_take = out_valid_reg && !out_stall;

    assign stat.item_op  = item_op_reg;
    assign stat.rd_empty = (rd_n == '0);
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || !out_stall;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_op_reg   <= op_t'(op);
            item_port_reg <= port;
            item_byte_reg <= rx_byte;
            item_max_reg  <= read_max;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            mask_reg <= cfg_data;
        end
    end

    // ring memory: write on store, registered read on drain
    always_ff @(posedge clk)
    begin
        if (cmd.single && item_op_reg == OP_STORE && st_code == ST_STORED)
        begin
            ring_mem[base_addr + AW'(wi_cur)] <= item_byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            mem_q_reg <= ring_mem[base_addr + AW'(ri_cur)];
        end
    end

    // per-port indexes and ready flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                wi_reg[i]   <= '0;
                ri_reg[i]   <= '0;
                flag_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.single && item_op_reg == OP_STORE && st_code == ST_STORED)
            begin
                wi_reg[pidx]   <= wi_inc;
                flag_reg[pidx] <= ({1'b0, fill_after} >= HALF_V);
            end
            if (cmd.single && item_op_reg == OP_POLL && port_ok && !ring_empty)
            begin
                flag_reg[pidx] <= 1'b1;
            end
            if (cmd.rd_issue)
            begin
                ri_reg[pidx] <= idx_inc(ri_cur);
            end
        end
    end

    // bytes left to drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.rd_start)
        begin
            cnt_reg <= rd_n;
        end
        else if (cmd.rd_issue)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.single || cmd.rd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            kind_reg   <= KIND_READ;
            status_reg <= ST_STORED;
            ready_reg  <= 1'b0;
            data_reg   <= mem_q_reg;
            dvalid_reg <= 1'b1;
            last_reg   <= (cnt_reg == '0);
        end
        else if (cmd.single)
        begin
            status_reg <= ST_STORED;
            ready_reg  <= 1'b0;
            data_reg   <= '0;
            dvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
            unique case (item_op_reg)
                OP_STORE:
                begin
                    kind_reg   <= KIND_STORE;
                    status_reg <= st_code;
                end
                OP_POLL:
                begin
                    kind_reg  <= KIND_POLL;
                    ready_reg <= poll_ans;
                end
                OP_READ:
                begin
                    kind_reg <= KIND_READ;
                end
                default:
                begin
                    kind_reg <= KIND_READ;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign store_status = status_reg;
    assign ready_res    = ready_reg;
    assign data         = data_reg;
    assign data_valid   = dvalid_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // a new result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.single || cmd.rd_load) |-> stat.out_free)
        else $error("result register overwritten while stalled");

    // a drain step never reads past the write index
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (ri_cur != wi_cur) && port_ok)
        else $error("drain read from an empty ring");

    // a drain only starts with bytes to move
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_start |=> (cnt_reg != '0))
        else $error("drain started with zero count");

    // the write index of the first port stays inside the ring
    a_wi_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wi_reg[0]} < RS_V))
        else $error("write index out of ring range");
`endif

endmodule
